// ----- rtl/vt_pkg.sv -----
// Shared types and constants for the vertex transform block.
// Holds the payload words, the stage enable group and the action codes.
// No dependencies.
package vt_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int STORE_DEPTH = 32;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int MAT_SIZE    = 16;
    localparam int ROW_SIZE    = 4;
    localparam int CLIP_BASE   = MAT_SIZE;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_XFORM = 1'b1
    } vt_action_t;

    typedef struct packed {
        logic                         action;
        logic [IDX_W-1:0]             element_index;
        logic signed [DATA_WIDTH-1:0] element_value;
        logic signed [DATA_WIDTH-1:0] pos_x;
        logic signed [DATA_WIDTH-1:0] pos_y;
        logic signed [DATA_WIDTH-1:0] pos_z;
        logic signed [DATA_WIDTH-1:0] nrm_x;
        logic signed [DATA_WIDTH-1:0] nrm_y;
        logic signed [DATA_WIDTH-1:0] nrm_z;
    } vt_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] clip_x;
        logic signed [DATA_WIDTH-1:0] clip_y;
        logic signed [DATA_WIDTH-1:0] clip_z;
        logic signed [DATA_WIDTH-1:0] clip_w;
        logic signed [DATA_WIDTH-1:0] view_x;
        logic signed [DATA_WIDTH-1:0] view_y;
        logic signed [DATA_WIDTH-1:0] view_z;
        logic signed [DATA_WIDTH-1:0] vnorm_x;
        logic signed [DATA_WIDTH-1:0] vnorm_y;
        logic signed [DATA_WIDTH-1:0] vnorm_z;
    } vt_out_t;

    // Load enables for the partial product stage and the full product stage.
    typedef struct packed {
        logic s1;
        logic s2;
    } vt_en_t;

endpackage

// ----- rtl/vt_mul.sv -----
// Two-stage signed multiplier built from half-width partial products.
// Depends on vt_pkg for the stage enable type.
module vt_mul #(
    parameter int W = vt_pkg::DATA_WIDTH
) (
    input  logic                  clk,
    input  vt_pkg::vt_en_t        en,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);
    import vt_pkg::*;

    localparam int L = W / 2;
    localparam int H = W - L;

    logic signed [L:0]       al_s;
    logic signed [L:0]       bl_s;
    logic signed [H-1:0]     ah;
    logic signed [H-1:0]     bh;

    logic [2*L-1:0]          ll_reg;
    logic [2*L-1:0]          ll_next;
    logic signed [L+H:0]     lh_reg;
    logic signed [L+H:0]     lh_next;
    logic signed [L+H:0]     hl_reg;
    logic signed [L+H:0]     hl_next;
    logic signed [2*H-1:0]   hh_reg;
    logic signed [2*H-1:0]   hh_next;

    logic signed [2*W-1:0]   p_reg;
    logic signed [2*W-1:0]   p_next;
    logic signed [2*W-1:0]   hh_x;
    logic signed [2*W-1:0]   lh_x;
    logic signed [2*W-1:0]   hl_x;
    logic [2*W-1:0]          ll_x;

    // The low halves are unsigned; a zero on top makes them signed operands.
    assign al_s = $signed({1'b0, a[L-1:0]});
    assign bl_s = $signed({1'b0, b[L-1:0]});
    assign ah   = a[W-1:L];
    assign bh   = b[W-1:L];

    assign ll_next = a[L-1:0] * b[L-1:0];
    assign lh_next = al_s * bh;
    assign hl_next = ah * bl_s;
    assign hh_next = ah * bh;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
        end
    end

    assign hh_x = (2*W)'(hh_reg);
    assign lh_x = (2*W)'(lh_reg);
    assign hl_x = (2*W)'(hl_reg);
    assign ll_x = (2*W)'(ll_reg);

    assign p_next = (hh_x <<< (2*L)) + (lh_x <<< L) + (hl_x <<< L) + $signed(ll_x);

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/vt_dot.sv -----
// One matrix row times a three-element vector plus an offset term.
// Depends on vt_pkg and vt_mul; the sum is shifted and saturated after stage two.
module vt_dot #(
    parameter int W = vt_pkg::DATA_WIDTH
) (
    input  logic                clk,
    input  vt_pkg::vt_en_t      en,
    input  logic signed [W-1:0] m [3],
    input  logic signed [W-1:0] vec [3],
    input  logic signed [W-1:0] offset,
    output logic signed [W-1:0] result
);
    import vt_pkg::*;

    localparam int SW = 2 * W + 2;
    localparam logic signed [SW-1:0] SMAX = (SW)'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [SW-1:0] SMIN = ~SMAX;

    logic signed [2*W-1:0] prod [3];
    logic signed [W-1:0]   off1_reg;
    logic signed [W-1:0]   off2_reg;
    logic signed [SW-1:0]  sum;
    logic signed [SW-1:0]  shifted;

    for (genvar c = 0; c < 3; c++)
    begin : g_mul
        vt_mul #(
            .W (W)
        ) u_mul (
            .clk (clk),
            .en  (en),
            .a   (m[c]),
            .b   (vec[c]),
            .p   (prod[c])
        );
    end

    // The offset is the column-3 element times 1.0, which is an exact shift.
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            off1_reg <= offset;
        end
        if (en.s2)
        begin
            off2_reg <= off1_reg;
        end
    end

    assign sum = (SW)'(prod[0]) + (SW)'(prod[1]) + (SW)'(prod[2])
               + ((SW)'(off2_reg) <<< FRAC_BITS);
    assign shifted = sum >>> FRAC_BITS;

    always_comb
    begin
        if (shifted > SMAX)
        begin
            result = SMAX[W-1:0];
        end
        else if (shifted < SMIN)
        begin
            result = SMIN[W-1:0];
        end
        else
        begin
            result = shifted[W-1:0];
        end
    end

endmodule

// ----- rtl/vertex_transform.sv -----
// Top level of the vertex transform block: matrix element store, handshake
// control and the ten row dot units. Depends on vt_pkg, vt_dot and vt_mul.
//
// A write word stores one Q16.16 matrix element (index = matrix*16 + row*4 +
// column; matrix 0 is world-view, matrix 1 is world-view-projection) and gives
// no result. A transform word gives one result word: clip position, view
// position and view normal, each component floor-shifted by 16 and saturated.
// The block takes one word per cycle, writes and transforms alike, while the
// output is not stalled. A transform's result passes through the input
// register, the two multiplier stages, which form each product from half-width
// partial products, and the sum and saturation logic feeding the output
// register. The 32 elements sit in flip-flops cleared by reset, so the block is
// usable straight out of reset.
// Writes take effect in order with transforms: a transform sees every element
// written by words accepted before it and none written after it.
module vertex_transform (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            vtx_valid,
    output logic            vtx_ready,
    input  vt_pkg::vt_in_t  vtx,
    output logic            res_valid,
    input  logic            res_ready,
    output vt_pkg::vt_out_t res
);
    import vt_pkg::*;

    logic signed [DATA_WIDTH-1:0] store_reg [STORE_DEPTH];

    logic    v0_reg;
    logic    v1_reg;
    logic    v2_reg;
    logic    res_valid_reg;
    vt_in_t  in_reg;
    vt_out_t res_reg;
    vt_out_t res_next;

    logic    is_xf;
    logic    room1;
    logic    room2;
    logic    room3;
    logic    go0;
    logic    go1;
    logic    go2;
    vt_en_t  en;

    logic signed [DATA_WIDTH-1:0] pos_vec [3];
    logic signed [DATA_WIDTH-1:0] nrm_vec [3];
    logic signed [DATA_WIDTH-1:0] clip_res [4];
    logic signed [DATA_WIDTH-1:0] view_res [3];
    logic signed [DATA_WIDTH-1:0] vnorm_res [3];

    // Each stage moves on when the next is empty or moving on; writes never wait.
    assign is_xf = (in_reg.action == ACT_XFORM);
    assign room3 = !res_valid_reg || res_ready;
    assign go2   = v2_reg && room3;
    assign room2 = !v2_reg || go2;
    assign go1   = v1_reg && room2;
    assign room1 = !v1_reg || go1;
    assign go0   = v0_reg && (!is_xf || room1);
    assign vtx_ready = !v0_reg || go0;

    assign en = {go0 && is_xf, go1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (vtx_ready)
            begin
                v0_reg <= vtx_valid;
            end
            if (room1)
            begin
                v1_reg <= en.s1;
            end
            if (room2)
            begin
                v2_reg <= go1;
            end
            if (room3)
            begin
                res_valid_reg <= go2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (vtx_ready && vtx_valid)
        begin
            in_reg <= vtx;
        end
        if (go2)
        begin
            res_reg <= res_next;
        end
    end

    // A write lands as it leaves the input register, in order with transforms.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (go0 && !is_xf)
        begin
            store_reg[in_reg.element_index] <= in_reg.element_value;
        end
    end

    assign pos_vec[0] = in_reg.pos_x;
    assign pos_vec[1] = in_reg.pos_y;
    assign pos_vec[2] = in_reg.pos_z;
    assign nrm_vec[0] = in_reg.nrm_x;
    assign nrm_vec[1] = in_reg.nrm_y;
    assign nrm_vec[2] = in_reg.nrm_z;

    for (genvar r = 0; r < 4; r++)
    begin : g_clip
        logic signed [DATA_WIDTH-1:0] row [3];
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            assign row[c] = store_reg[CLIP_BASE + r * ROW_SIZE + c];
        end
        vt_dot #(
            .W (DATA_WIDTH)
        ) u_dot (
            .clk    (clk),
            .en     (en),
            .m      (row),
            .vec    (pos_vec),
            .offset (store_reg[CLIP_BASE + r * ROW_SIZE + 3]),
            .result (clip_res[r])
        );
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_view
        logic signed [DATA_WIDTH-1:0] row [3];
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            assign row[c] = store_reg[r * ROW_SIZE + c];
        end
        vt_dot #(
            .W (DATA_WIDTH)
        ) u_pos (
            .clk    (clk),
            .en     (en),
            .m      (row),
            .vec    (pos_vec),
            .offset (store_reg[r * ROW_SIZE + 3]),
            .result (view_res[r])
        );
        // Normals carry no translation.
        vt_dot #(
            .W (DATA_WIDTH)
        ) u_nrm (
            .clk    (clk),
            .en     (en),
            .m      (row),
            .vec    (nrm_vec),
            .offset ('0),
            .result (vnorm_res[r])
        );
    end

    always_comb
    begin
        res_next.clip_x  = clip_res[0];
        res_next.clip_y  = clip_res[1];
        res_next.clip_z  = clip_res[2];
        res_next.clip_w  = clip_res[3];
        res_next.view_x  = view_res[0];
        res_next.view_y  = view_res[1];
        res_next.view_z  = view_res[2];
        res_next.vnorm_x = vnorm_res[0];
        res_next.vnorm_y = vnorm_res[1];
        res_next.vnorm_z = vnorm_res[2];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // With the output register empty, nothing upstream can be held back.
    a_ready_when_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> vtx_ready
    ) else $error("input stalled while output register is empty");

    // A write word never waits in the input register.
    a_write_never_stalls: assert property (
        @(posedge clk) disable iff (!rst_n)
        (v0_reg && !is_xf) |-> vtx_ready
    ) else $error("write word stalled");

    // A transform loaded into the partial product stage is valid there next cycle.
    a_stage1_load: assert property (
        @(posedge clk) disable iff (!rst_n)
        en.s1 |=> v1_reg
    ) else $error("stage one lost a transform");

    // A result only appears after the full product stage held a transform.
    a_result_source: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(v2_reg)
    ) else $error("result appeared without a transform behind it");

endmodule
